// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Clock aclk, reset aresetn (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define QS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qslerp_pkg.sv =====
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared constants and the arctangent table for the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS_DEF    = 16;

    localparam int BLEND_W = 17;                       // t in Q1.16
    localparam logic [BLEND_W-1:0] ONE_Q16 = 17'h10000;
    localparam int FRAC_SH = 16;

    localparam int THR_W  = 15;
    localparam int THR_SH = 15;                        // Q0.15 -> Q.30
    localparam logic [THR_W-1:0] THR_RESET = 15'h7FFF;

    localparam int DOT_W = 34;                         // signed Q.30 sum of four terms
    localparam int COS_W = 30;                         // |d| on the spherical path
    localparam int RAD_W = 61;                         // 2^60 - d*d
    localparam logic [RAD_W-1:0] ONE_Q60 = {1'b1, {(RAD_W-1){1'b0}}};
    localparam int SQ_W       = 62;
    localparam int SQRT_STEPS = 31;
    localparam int SIN_W      = 31;                    // sin in [0, 2^30]
    localparam logic [SIN_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [SIN_W-1:0] MIN_SIN = 31'h0040_0000;

    localparam int CORD_W = 34;
    localparam int ATAN_W = 30;
    localparam logic [CORD_W-1:0] INV_GAIN = 34'd652032874;

    localparam int DIV_NUM_W = SIN_W + FRAC_SH;        // 47
    localparam int DIV_Q_W   = 25;

    function automatic logic [ATAN_W-1:0] atan_q30(input int idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:  v = 30'd843314856;
            1:  v = 30'd497837829;
            2:  v = 30'd263043836;
            3:  v = 30'd133525158;
            4:  v = 30'd67021686;
            5:  v = 30'd33543515;
            6:  v = 30'd16775850;
            7:  v = 30'd8388437;
            8:  v = 30'd4194282;
            9:  v = 30'd2097149;
            10: v = 30'd1048575;
            11: v = 30'd524287;
            12: v = 30'd262143;
            13: v = 30'd131071;
            14: v = 30'd65535;
            15: v = 30'd32767;
            16: v = 30'd16383;
            17: v = 30'd8191;
            18: v = 30'd4095;
            19: v = 30'd2047;
            20: v = 30'd1023;
            21: v = 30'd511;
            22: v = 30'd255;
            23: v = 30'd127;
            24: v = 30'd63;
            25: v = 30'd31;
            26: v = 30'd15;
            27: v = 30'd7;
            28: v = 30'd3;
            29: v = 30'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qslerp_cordic.sv =====
// ----------------------------------------------------------------------------
// qslerp_cordic
// Pipelined CORDIC, one micro-rotation per stage; vectoring or rotation mode.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_cordic #(
    parameter int STEPS     = qslerp_pkg::CORDIC_STEPS_DEF,
    parameter bit VECTORING = 1'b0,
    parameter int SIDE_W    = 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [qslerp_pkg::CORD_W-1:0] in_x,
    input  logic signed [qslerp_pkg::CORD_W-1:0] in_y,
    input  logic signed [qslerp_pkg::CORD_W-1:0] in_z,
    input  logic [SIDE_W-1:0]                    in_side,
    output logic                                 out_valid,
    output logic signed [qslerp_pkg::CORD_W-1:0] out_res,   // angle or sine
    output logic [SIDE_W-1:0]                    out_side
);
    import qslerp_pkg::*;

    logic signed [CORD_W-1:0] x_reg [STEPS];
    logic signed [CORD_W-1:0] y_reg [STEPS];
    logic signed [CORD_W-1:0] z_reg [STEPS];
    logic [SIDE_W-1:0]        side_reg [STEPS];
    logic [STEPS-1:0]         v_reg;

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        localparam logic signed [CORD_W-1:0] ANG = CORD_W'(atan_q30(i));
        logic signed [CORD_W-1:0] xi, yi, zi, xs, ys, x_next, y_next, z_next;
        logic                     vi;
        logic [SIDE_W-1:0]        si;

        if (i == 0) begin : g_first
            assign xi = in_x;
            assign yi = in_y;
            assign zi = in_z;
            assign vi = in_valid;
            assign si = in_side;
        end else begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
            assign vi = v_reg[i-1];
            assign si = side_reg[i-1];
        end

        always_comb begin
            xs = xi >>> i;
            ys = yi >>> i;
            if (VECTORING ? (yi > 0) : (zi < 0)) begin
                x_next = xi + ys;
                y_next = yi - xs;
                z_next = VECTORING ? zi + ANG : zi + ANG;
            end else begin
                x_next = xi - ys;
                y_next = yi + xs;
                z_next = zi - ANG;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                z_reg[i]    <= z_next;
                side_reg[i] <= si;
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign out_res   = VECTORING ? z_reg[STEPS-1] : y_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/qslerp_div.sv =====
// ----------------------------------------------------------------------------
// qslerp_div
// Pipelined restoring divider, one quotient bit per stage. The numerator's
// top bits must already be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_div #(
    parameter int SIDE_W = 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [qslerp_pkg::DIV_NUM_W-1:0]    in_num,
    input  logic [qslerp_pkg::SIN_W-1:0]        in_den,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    output logic [qslerp_pkg::DIV_Q_W-1:0]      out_quo,
    output logic [SIDE_W-1:0]                   out_side
);
    import qslerp_pkg::*;

    localparam int QW = DIV_Q_W;

    logic [SIN_W-1:0]  rem_reg [QW];
    logic [SIN_W-1:0]  den_reg [QW];
    logic [QW-1:0]     low_reg [QW];
    logic [QW-1:0]     quo_reg [QW];
    logic [SIDE_W-1:0] side_reg [QW];
    logic [QW-1:0]     v_reg;

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int K = QW - 1 - j;
        logic [SIN_W-1:0]  ri, di, r_next;
        logic [QW-1:0]     li, qi, q_next;
        logic [SIN_W:0]    trial, diff;
        logic              vi, ge;
        logic [SIDE_W-1:0] si;

        if (j == 0) begin : g_first
            assign ri = SIN_W'(in_num[DIV_NUM_W-1:QW]);
            assign di = in_den;
            assign li = in_num[QW-1:0];
            assign qi = '0;
            assign vi = in_valid;
            assign si = in_side;
        end else begin : g_next
            assign ri = rem_reg[j-1];
            assign di = den_reg[j-1];
            assign li = low_reg[j-1];
            assign qi = quo_reg[j-1];
            assign vi = v_reg[j-1];
            assign si = side_reg[j-1];
        end

        always_comb begin
            trial  = {ri, li[K]};
            diff   = trial - {1'b0, di};
            ge     = trial >= {1'b0, di};
            r_next = ge ? diff[SIN_W-1:0] : trial[SIN_W-1:0];
            q_next = qi;
            q_next[K] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= r_next;
                den_reg[j]  <= di;
                low_reg[j]  <= li;
                quo_reg[j]  <= q_next;
                side_reg[j] <= si;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

// ===== rtl/quaternion_slerp.sv =====
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point spherical linear interpolation of two Q1.15 quaternions.
// ----------------------------------------------------------------------------
// Usage notes
//   s_ channel: one word = quaternions a, b and blend fraction t (Q1.16,
//   values above one are taken as one). m_ channel: one word = the
//   interpolated quaternion, each component saturated.
//   cfg_ channel: writes the near-parallel threshold (Q0.15); always ready.
//   Write it only while the pipeline is empty.
//   Throughput: one word per cycle while the pipeline is not stalled.
//   Depth is set by the 31-stage square root, the vectoring CORDIC, the two
//   rotation CORDICs running side by side and the 25-stage dividers.
//   Stall: the whole pipeline moves on one enable. It keeps moving while the
//   output register is free or while its last stage holds a bubble, so
//   words are still taken behind a waiting result until the pipe fills.
//   Nothing is dropped or repeated.
//   Reset (aresetn low, synchronous): all valid bits clear, threshold
//   returns to 32767.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module quaternion_slerp #(
    parameter int COMPONENT_WIDTH = qslerp_pkg::COMPONENT_WIDTH_DEF,
    parameter int CORDIC_STEPS    = qslerp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qslerp_pkg::THR_W-1:0]        cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_x, first_y, first_z, first_w, second_x, second_y, second_z,
    // second_w, blend_fraction, zero pad
    input  logic [((8*COMPONENT_WIDTH+qslerp_pkg::BLEND_W+7)/8)*8-1:0] s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_x, out_y, out_z, out_w, zero pad
    output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_tdata
);
    import qslerp_pkg::*;

    localparam int W      = COMPONENT_WIDTH;
    localparam int OUT_TW = ((4*W + 7) / 8) * 8;
    localparam int AB_W   = 8*W + 4;                   // a (4 x W), -b or b (4 x W+1)
    localparam int PW     = W + DIV_Q_W + 2;
    localparam int SUM_W  = PW + 1;
    localparam int SHR    = (W >= 16) ? 2*W - 32 : 0;
    localparam int SHL    = (W >= 16) ? 0 : 32 - 2*W;
    localparam int SQS_W  = AB_W + BLEND_W + 1 + COS_W;
    localparam int VS_W   = AB_W + BLEND_W + 1 + SIN_W;
    localparam int R1_W   = BLEND_W + 1 + SIN_W;
    localparam int ANG_PW = CORD_W + BLEND_W + 1;
    localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) <<< (FRAC_SH - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    // flow control
    logic adv, out_free;

    // configuration
    logic [THR_W-1:0] thr_reg;

    // stage 1: captured word
    logic                 v1_reg;
    logic signed [W-1:0]  a1_reg [4];
    logic signed [W-1:0]  b1_reg [4];
    logic [BLEND_W-1:0]   t1_reg, t_raw, t_next;

    // stage 2: component products
    logic                   v2_reg;
    logic signed [2*W-1:0]  p2_reg [4];
    logic signed [W-1:0]    a2_reg [4];
    logic signed [W-1:0]    b2_reg [4];
    logic [BLEND_W-1:0]     t2_reg;

    // stage 3: dot product
    logic                   v3_reg;
    logic signed [63:0]     p_ext [4];
    logic signed [DOT_W-1:0] term [4];
    logic signed [DOT_W-1:0] d_next, d3_reg;
    logic signed [W-1:0]    a3_reg [4];
    logic signed [W-1:0]    b3_reg [4];
    logic [BLEND_W-1:0]     t3_reg;

    // stage 4: short arc, threshold
    logic                 v4_reg, lin4_reg, neg, lin_next;
    logic [DOT_W-1:0]     dabs;
    logic signed [W:0]    bx [4];
    logic signed [W:0]    bn [4];
    logic [AB_W-1:0]      ab_next, ab4_reg, ab5_reg;
    logic [BLEND_W-1:0]   t4_reg, t5_reg;
    logic [COS_W-1:0]     c4_reg, c5_reg;

    // stages 5 and 6: d*d, 2^60 - d*d
    logic                 v5_reg, lin5_reg, v6_reg;
    logic [2*COS_W-1:0]   dd5_reg;
    logic [RAD_W-1:0]     rad6_reg;
    logic [SQS_W-1:0]     side6_reg;

    // square root
    logic [SQ_W-1:0]      sq_rem_reg  [SQRT_STEPS];
    logic [SQ_W-1:0]      sq_res_reg  [SQRT_STEPS];
    logic [SQS_W-1:0]     sq_side_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] sq_v_reg;
    logic [SIN_W-1:0]     s_root;
    logic [SQS_W-1:0]     sq_side;

    // vectoring CORDIC
    logic                    vec_v;
    logic signed [CORD_W-1:0] vec_w;
    logic [VS_W-1:0]         vec_side_in, vec_side;
    logic [BLEND_W-1:0]      vec_t;

    // angle products
    logic                     ang_v_reg;
    logic signed [ANG_PW-1:0] pr0_reg, pr1_reg;
    logic [VS_W-1:0]          ang_side_reg;

    // rotation CORDICs
    logic                     r0_v, r1_v, r1_lin;
    logic signed [CORD_W-1:0] r0_y, r1_y;
    logic [AB_W-1:0]          r0_side;
    logic [R1_W-1:0]          r1_side;
    logic [SIN_W-1:0]         r1_s, yc0, yc1;
    logic [BLEND_W-1:0]       r1_t;
    logic [DIV_NUM_W-1:0]     num0, num1;

    // dividers
    logic                   q0_v, q1_v, fin_lin;
    logic [DIV_Q_W-1:0]     q0, q1, k0, k1;
    logic [AB_W-1:0]        q0_side;
    logic [BLEND_W:0]       q1_side;
    logic [BLEND_W-1:0]     fin_t;

    // blend and output
    logic                   vb_reg;
    logic signed [PW-1:0]   pa_reg [4];
    logic signed [PW-1:0]   pb_reg [4];
    logic signed [SUM_W-1:0] sum_c [4];
    logic signed [SUM_W-1:0] shr_c [4];
    logic [W-1:0]           sat_next [4];
    logic [W-1:0]           out_reg [4];
    logic                   m_tvalid_reg;

    // ------------------------------------------------------------------
    // Flow control: advance whenever the output register can take a word
    // or the last stage is empty.
    // ------------------------------------------------------------------
    assign out_free = !m_tvalid_reg || m_tready;
    assign adv      = out_free || !vb_reg;
    assign s_tready = adv;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1..6: capture, products, dot, short arc, d*d, radicand
    // ------------------------------------------------------------------
    assign t_raw  = s_tdata[8*W +: BLEND_W];
    assign t_next = (t_raw > ONE_Q16) ? ONE_Q16 : t_raw;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            p_ext[i] = 64'(p2_reg[i]);
            term[i]  = DOT_W'((p_ext[i] <<< SHL) >>> SHR);
        end
        d_next = term[0] + term[1] + term[2] + term[3];
    end

    always_comb begin
        neg      = d3_reg[DOT_W-1];
        dabs     = neg ? DOT_W'(-d3_reg) : DOT_W'(d3_reg);
        lin_next = dabs > DOT_W'({thr_reg, {THR_SH{1'b0}}});
        ab_next  = '0;
        for (int i = 0; i < 4; i++) begin
            bx[i] = {b3_reg[i][W-1], b3_reg[i]};
            bn[i] = neg ? -bx[i] : bx[i];
            ab_next[i*W +: W]             = a3_reg[i];
            ab_next[4*W + i*(W+1) +: W+1] = bn[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                a1_reg[i] <= s_tdata[i*W +: W];
                b1_reg[i] <= s_tdata[(4+i)*W +: W];
                p2_reg[i] <= a1_reg[i] * b1_reg[i];
                a2_reg[i] <= a1_reg[i];
                b2_reg[i] <= b1_reg[i];
                a3_reg[i] <= a2_reg[i];
                b3_reg[i] <= b2_reg[i];
            end
            t1_reg    <= t_next;
            t2_reg    <= t1_reg;
            d3_reg    <= d_next;
            t3_reg    <= t2_reg;
            ab4_reg   <= ab_next;
            t4_reg    <= t3_reg;
            lin4_reg  <= lin_next;
            c4_reg    <= dabs[COS_W-1:0];
            dd5_reg   <= c4_reg * c4_reg;
            ab5_reg   <= ab4_reg;
            t5_reg    <= t4_reg;
            lin5_reg  <= lin4_reg;
            c5_reg    <= c4_reg;
            rad6_reg  <= ONE_Q60 - RAD_W'(dd5_reg);
            side6_reg <= {ab5_reg, t5_reg, lin5_reg, c5_reg};
        end
    end

    // ------------------------------------------------------------------
    // Square root, one result bit per stage: sin w = isqrt(2^60 - d*d)
    // ------------------------------------------------------------------
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2*(SQRT_STEPS - 1 - j));
        logic [SQ_W-1:0]  rem_in, res_in, trial, rem_next, res_next;
        logic             v_in, ge;
        logic [SQS_W-1:0] side_in;

        if (j == 0) begin : g_first
            assign rem_in  = SQ_W'(rad6_reg);
            assign res_in  = '0;
            assign v_in    = v6_reg;
            assign side_in = side6_reg;
        end else begin : g_next
            assign rem_in  = sq_rem_reg[j-1];
            assign res_in  = sq_res_reg[j-1];
            assign v_in    = sq_v_reg[j-1];
            assign side_in = sq_side_reg[j-1];
        end

        always_comb begin
            trial    = res_in + BITV;
            ge       = rem_in >= trial;
            rem_next = ge ? rem_in - trial : rem_in;
            res_next = ge ? (res_in >> 1) + BITV : res_in >> 1;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[j] <= 1'b0;
            end else if (adv) begin
                sq_v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[j]  <= rem_next;
                sq_res_reg[j]  <= res_next;
                sq_side_reg[j] <= side_in;
            end
        end
    end

    assign s_root  = sq_res_reg[SQRT_STEPS-1][SIN_W-1:0];
    assign sq_side = sq_side_reg[SQRT_STEPS-1];

    // a zero sine falls back to linear weights
    assign vec_side_in = {sq_side[SQS_W-1:COS_W+1], sq_side[COS_W] | (s_root == '0), s_root};

    // ------------------------------------------------------------------
    // w = atan2(sin w, d)
    // ------------------------------------------------------------------
    qslerp_cordic #(
        .STEPS    (CORDIC_STEPS),
        .VECTORING(1'b1),
        .SIDE_W   (VS_W)
    ) u_vec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (sq_v_reg[SQRT_STEPS-1]),
        .in_x     (CORD_W'(sq_side[COS_W-1:0])),
        .in_y     (CORD_W'(s_root)),
        .in_z     ('0),
        .in_side  (vec_side_in),
        .out_valid(vec_v),
        .out_res  (vec_w),
        .out_side (vec_side)
    );

    // (1-t)w and t w, floor shift by 16 taken at the CORDIC inputs
    assign vec_t = vec_side[SIN_W+1 +: BLEND_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ang_v_reg <= 1'b0;
        end else if (adv) begin
            ang_v_reg <= vec_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pr0_reg      <= $signed({1'b0, ONE_Q16 - vec_t}) * vec_w;
            pr1_reg      <= $signed({1'b0, vec_t}) * vec_w;
            ang_side_reg <= vec_side;
        end
    end

    // ------------------------------------------------------------------
    // sin((1-t)w) and sin(t w), side by side
    // ------------------------------------------------------------------
    qslerp_cordic #(
        .STEPS    (CORDIC_STEPS),
        .VECTORING(1'b0),
        .SIDE_W   (AB_W)
    ) u_rot0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (ang_v_reg),
        .in_x     ($signed(INV_GAIN)),
        .in_y     ('0),
        .in_z     ($signed(pr0_reg[CORD_W+FRAC_SH-1:FRAC_SH])),
        .in_side  (ang_side_reg[VS_W-1 -: AB_W]),
        .out_valid(r0_v),
        .out_res  (r0_y),
        .out_side (r0_side)
    );

    qslerp_cordic #(
        .STEPS    (CORDIC_STEPS),
        .VECTORING(1'b0),
        .SIDE_W   (R1_W)
    ) u_rot1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (ang_v_reg),
        .in_x     ($signed(INV_GAIN)),
        .in_y     ('0),
        .in_z     ($signed(pr1_reg[CORD_W+FRAC_SH-1:FRAC_SH])),
        .in_side  (ang_side_reg[R1_W-1:0]),
        .out_valid(r1_v),
        .out_res  (r1_y),
        .out_side (r1_side)
    );

    assign r1_s   = r1_side[SIN_W-1:0];
    assign r1_lin = r1_side[SIN_W];
    assign r1_t   = r1_side[SIN_W+1 +: BLEND_W];

    // clamp sines to [0, 1], then numerator = sine*2^16 + sin w / 2
    always_comb begin
        if (r0_y < 0) begin
            yc0 = '0;
        end else if (r0_y > $signed(CORD_W'(ONE_Q30))) begin
            yc0 = ONE_Q30;
        end else begin
            yc0 = r0_y[SIN_W-1:0];
        end
        if (r1_y < 0) begin
            yc1 = '0;
        end else if (r1_y > $signed(CORD_W'(ONE_Q30))) begin
            yc1 = ONE_Q30;
        end else begin
            yc1 = r1_y[SIN_W-1:0];
        end
        num0 = {yc0, {FRAC_SH{1'b0}}} + DIV_NUM_W'(r1_s >> 1);
        num1 = {yc1, {FRAC_SH{1'b0}}} + DIV_NUM_W'(r1_s >> 1);
    end

    // ------------------------------------------------------------------
    // Spherical weights in Q.16
    // ------------------------------------------------------------------
    qslerp_div #(
        .SIDE_W(AB_W)
    ) u_div0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (r0_v),
        .in_num   (num0),
        .in_den   (r1_s),
        .in_side  (r0_side),
        .out_valid(q0_v),
        .out_quo  (q0),
        .out_side (q0_side)
    );

    qslerp_div #(
        .SIDE_W(BLEND_W + 1)
    ) u_div1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (r1_v),
        .in_num   (num1),
        .in_den   (r1_s),
        .in_side  ({r1_t, r1_lin}),
        .out_valid(q1_v),
        .out_quo  (q1),
        .out_side (q1_side)
    );

    // ------------------------------------------------------------------
    // Blend: a*k0 + b*k1, round half up, saturate
    // ------------------------------------------------------------------
    assign fin_lin = q1_side[0];
    assign fin_t   = q1_side[1 +: BLEND_W];
    assign k0      = fin_lin ? DIV_Q_W'(ONE_Q16 - fin_t) : q0;
    assign k1      = fin_lin ? DIV_Q_W'(fin_t) : q1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (adv) begin
            vb_reg <= q0_v && q1_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                pa_reg[i] <= $signed(q0_side[i*W +: W]) * $signed({1'b0, k0});
                pb_reg[i] <= $signed(q0_side[4*W + i*(W+1) +: W+1]) * $signed({1'b0, k1});
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sum_c[i] = SUM_W'(pa_reg[i]) + SUM_W'(pb_reg[i]) + HALF;
            shr_c[i] = sum_c[i] >>> FRAC_SH;
            if (shr_c[i] > SAT_HI) begin
                sat_next[i] = SAT_HI[W-1:0];
            end else if (shr_c[i] < SAT_LO) begin
                sat_next[i] = SAT_LO[W-1:0];
            end else begin
                sat_next[i] = shr_c[i][W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && vb_reg) begin
            for (int i = 0; i < 4; i++) begin
                out_reg[i] <= sat_next[i];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'({out_reg[3], out_reg[2], out_reg[1], out_reg[0]});

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `QS_ASSERT(a_ready_when_taken, m_tready |-> s_tready, "input stalled with output ready")
    `QS_ASSERT(a_stall_blocks, (m_tvalid && !m_tready && vb_reg) |-> !s_tready, "word lost in stall")
    `QS_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v1_reg, "accepted word not captured")
    `QS_ASSERT(a_div_range, (r1_v && !r1_lin) |-> (r1_s >= MIN_SIN), "divisor below range")
    `QS_ASSERT_NEXT(a_drain, m_tvalid && m_tready && !vb_reg, !m_tvalid, "word repeated")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quaternion_slerp: a bit-exact predictor in fixed
// point, queued stimulus with random gaps and stalls, per-field comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qslerp_pkg::*;

    localparam int CW        = 16;
    localparam int STEPS     = 16;
    localparam int IN_W      = ((8*CW+BLEND_W+7)/8)*8;   // 152
    localparam int OUT_W     = ((4*CW+7)/8)*8;           // 64
    localparam int LATENCY   = 65 + 2*STEPS;
    localparam int N_RANDOM  = 1350;
    localparam longint LIMIT = 400000;

    typedef struct {
        logic signed [CW-1:0] a [4];
        logic signed [CW-1:0] b [4];
        logic [BLEND_W-1:0]   t;
    } slerp_word_t;

    typedef struct {
        logic signed [CW-1:0] q [4];
    } quat_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [THR_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // first_x, first_y, first_z, first_w, second_x, second_y, second_z,
    // second_w, blend_fraction, zero pad
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // out_x, out_y, out_z, out_w
    logic [OUT_W-1:0]  m_tdata;

    quaternion_slerp #(.COMPONENT_WIDTH(CW), .CORDIC_STEPS(STEPS)) u_dut (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    longint unsigned thr_model = THR_RESET;
    longint          atan_tab [32] = '{843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127,
        63, 31, 15, 7, 3, 1, 0, 0};

    // >>> on longint is arithmetic, i.e. floor
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r = 0, bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint z = 0, xs, ys;
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += atan_tab[i];
            end else begin
                x -= ys; y += xs; z -= atan_tab[i];
            end
        end
        return z;
    endfunction

    function automatic longint sine_of(longint z);
        longint x = 652032874, y = 0, xs, ys;
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        if (y < 0) y = 0;
        if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
        return y;
    endfunction

    function automatic quat_t slerp_of(slerp_word_t w);
        quat_t  r;
        longint a [4], b [4], d, t, k0, k1, wang, s0, s1, v;
        longint unsigned s;
        d = 0;
        for (int i = 0; i < 4; i++) begin
            a[i] = w.a[i];
            b[i] = w.b[i];
            d += a[i] * b[i];                          // CW=16: shift of 0
        end
        if (d < 0) begin
            for (int i = 0; i < 4; i++) b[i] = -b[i];
            d = -d;
        end
        t = (w.t > ONE_Q16) ? 65536 : longint'(w.t);
        k0 = 65536 - t;
        k1 = t;
        if (d <= longint'(thr_model << 15)) begin
            s = int_sqrt((64'd1 << 60) - longint'(unsigned'(d) * unsigned'(d)));
            if (s != 0) begin
                wang = angle_of(longint'(s), d);
                s0 = sine_of(((65536 - t) * wang) >>> 16);
                s1 = sine_of((t * wang) >>> 16);
                k0 = longint'(((unsigned'(s0) << 16) + (s >> 1)) / s);
                k1 = longint'(((unsigned'(s1) << 16) + (s >> 1)) / s);
            end
        end
        for (int i = 0; i < 4; i++) begin
            v = (a[i] * k0 + b[i] * k1 + 32768) >>> 16;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            r.q[i] = v[CW-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver, monitor
    // ------------------------------------------------------------------
    slerp_word_t pending_words [$];
    quat_t       expected_quats [$];
    int          errors = 0;
    longint      cycles = 0;
    int          hold_off = 0;       // long receiver stall, cycles left
    int          s_gap = 0, m_gap = 0;
    bit          no_idle = 0;
    logic        s_tready_q;

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [IN_W-1:0] pack_word(slerp_word_t w);
        logic [IN_W-1:0] v = '0;
        for (int i = 0; i < 4; i++) begin
            v[i*CW +: CW]     = w.a[i];
            v[(4+i)*CW +: CW] = w.b[i];
        end
        v[8*CW +: BLEND_W] = w.t;
        return v;
    endfunction

    always @(posedge aclk) cycles <= cycles + 1;

    // sender: ready sampled at the rise, accept checked and new word presented at the fall
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready_q) begin
                expected_quats.push_back(slerp_of(pending_words.pop_front()));
            end
            if (!(s_tvalid && !s_tready_q)) begin
                if (s_gap > 0) begin
                    s_gap <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_word(pending_words[0]);
                    s_gap    <= gap_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        s_tready_q <= s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_quats.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                quat_t e;
                e = expected_quats.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (m_tdata[i*CW +: CW] !== e.q[i]) begin
                        $error("out_%s expected %0d actual %0d", i == 0 ? "x" : i == 1 ? "y" :
                               i == 2 ? "z" : "w", e.q[i],
                               $signed(m_tdata[i*CW +: CW]));
                        errors++;
                    end
                end
            end
        end
    end

    // receiver ready, changed at the fall
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap <= m_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_gap <= gap_len();
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    function automatic slerp_word_t rand_word(int mode);
        slerp_word_t w;
        int sel = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++) begin
            w.a[i] = $urandom;
            w.b[i] = $urandom;
        end
        if (mode == 1) begin
            // unit-ish quaternions; b close to +-a (sel below 4) to hit the near-parallel path
            for (int i = 0; i < 4; i++) begin
                w.a[i] = $signed($urandom_range(0, 32767)) - 16384;
                w.a[i] = w.a[i] >>> 1;
            end
            w.a[$urandom_range(0, 3)] = 16384 + $urandom_range(0, 8000);
            for (int i = 0; i < 4; i++) begin
                w.b[i] = (sel < 4) ? w.a[i] + $signed($urandom_range(0, 2000)) - 1000 :
                         $signed($urandom_range(0, 32767)) - 16384;
                if (sel[0]) w.b[i] = -w.b[i];
            end
        end
        w.t = (sel == 9) ? $urandom_range(65536, 131071) : $urandom_range(0, 65536);
        return w;
    endfunction

    task automatic drain();
        while (pending_words.size() != 0 || s_tvalid || expected_quats.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_thr(logic [THR_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        thr_model = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed();
        slerp_word_t w;
        logic signed [CW-1:0] ext [4] = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001};
        // extremes of every field, most negative component, t above one
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 4; i++) begin
                w.a[i] = ext[(k + i) % 4];
                w.b[i] = ext[(k + 2*i) % 4];
            end
            w.t = (k == 0) ? 0 : (k == 1) ? 65536 : (k == 2) ? 17'h1FFFF : 32768;
            pending_words.push_back(w);
        end
        // identical, opposite (negative dot), orthogonal, unnormalised
        for (int k = 0; k < 8; k++) begin
            w.a = '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
            case (k % 4)
                0: w.b = w.a;
                1: w.b = '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384};
                2: w.b = '{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384};
                default: w.b = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
            endcase
            w.t = (k < 4) ? 17'd16384 : 17'h10001;
            pending_words.push_back(w);
        end
        for (int k = 0; k < 8; k++) pending_words.push_back(rand_word(1));
    endtask

    initial begin
        logic [THR_W-1:0] thr_set [5] = '{15'h7FFF, 15'h0000, 15'h7F00, 15'h4000, 15'h7FFE};
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed();
        drain();
        for (int p = 0; p < 5; p++) begin
            write_thr(thr_set[p]);
            if (p == 4) directed();
            if (p == 2) begin
                // long stall against a steady sender so the pipe fills
                no_idle = 1;
                hold_off = 300;
            end
            for (int n = 0; n < N_RANDOM / 5; n++)
                pending_words.push_back(rand_word($urandom_range(0, 3) != 0));
            drain();
            no_idle = ($urandom_range(0, 1) == 1);
        end
        if (errors == 0) $display("PASS quaternion_slerp");
        else $display("FAIL quaternion_slerp");
        $finish;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("FAIL quaternion_slerp");
        $finish;
    end

endmodule

`default_nettype wire
